FILE: rtl/trilinear_voxel_sampler_top_defines.svh
// assertion macros for the trilinear voxel sampler
// expects clk and rst_n in the scope where a macro is used
`ifndef TRILINEAR_VOXEL_SAMPLER_TOP_DEFINES_SVH
`define TRILINEAR_VOXEL_SAMPLER_TOP_DEFINES_SVH

// same-cycle implication
`define TVS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TVS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tvs_pkg.sv
// shared constants and codes of the trilinear voxel sampler
// no dependencies
package tvs_pkg;

    localparam int POS_W     = 17;
    localparam int VOXEL_W   = 16;
    localparam int WCOORD_W  = 5;
    localparam int DIM_REG_W = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_X = 2'd0,
        REG_DIM_Y = 2'd1,
        REG_DIM_Z = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_t;

endpackage

FILE: rtl/tvs_if.sv
// valid/ready channel interfaces for request and result items
// depends on tvs_pkg
interface tvs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [tvs_pkg::WCOORD_W-1:0]        write_x;
    logic [tvs_pkg::WCOORD_W-1:0]        write_y;
    logic [tvs_pkg::WCOORD_W-1:0]        write_z;
    logic [tvs_pkg::VOXEL_W-1:0]         voxel_value;
    logic signed [tvs_pkg::POS_W-1:0]    pos_x;
    logic signed [tvs_pkg::POS_W-1:0]    pos_y;
    logic signed [tvs_pkg::POS_W-1:0]    pos_z;

    modport source (output valid, req_type, write_x, write_y, write_z, voxel_value,
                    pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, req_type, write_x, write_y, write_z, voxel_value,
                    pos_x, pos_y, pos_z, output ready);
endinterface

interface tvs_out_if;
    logic                          valid;
    logic                          ready;
    logic [tvs_pkg::VOXEL_W-1:0]   sample_value;

    modport source (output valid, sample_value, input ready);
    modport sink   (input valid, sample_value, output ready);
endinterface

FILE: rtl/tvs_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: rtl/tvs_axis.sv
// per-axis split: half-voxel shift, clamp, corner index and weights
// depends on tvs_pkg
module tvs_axis #(
    parameter int DIM_BITS  = 5,
    parameter int FRAC_BITS = 10
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [tvs_pkg::POS_W-1:0]         pos,
    input  logic [tvs_pkg::DIM_REG_W-1:0]     dim,
    output logic [DIM_BITS-1:0]               lo_reg,
    output logic [FRAC_BITS:0]                wlo_reg,
    output logic [FRAC_BITS:0]                whi_reg
);
    localparam int PW   = tvs_pkg::POS_W;
    localparam int IPW  = PW - 1 - FRAC_BITS;
    localparam int CW1  = (IPW > DIM_BITS + 1) ? IPW : DIM_BITS + 1;
    localparam int CW   = (CW1 > tvs_pkg::DIM_REG_W) ? CW1 : tvs_pkg::DIM_REG_W;
    localparam int HALF = 1 << (FRAC_BITS - 1);
    localparam int ONE  = 1 << FRAC_BITS;
    localparam int DMAX = 1 << DIM_BITS;

    logic [PW:0]            shifted;
    logic [PW-2:0]          p;
    logic [IPW-1:0]         ip;
    logic [FRAC_BITS-1:0]   f;
    logic [CW-1:0]          dim_ext;
    logic [CW-1:0]          eff;
    logic [CW-1:0]          top;
    logic [CW-1:0]          ip_ext;
    logic                   same;
    logic [DIM_BITS-1:0]    lo_next;
    logic [FRAC_BITS:0]     wlo_next;
    logic [FRAC_BITS:0]     whi_next;

    always_comb
    begin
        shifted = {pos[PW-1], pos} - (PW + 1)'(HALF);
        p       = shifted[PW] ? '0 : shifted[PW-2:0];
        ip      = p[PW-2:FRAC_BITS];
        f       = p[FRAC_BITS-1:0];
        dim_ext = CW'(dim);
        if (dim_ext == '0)
        begin
            eff = CW'(1);
        end
        else if (dim_ext > CW'(DMAX))
        begin
            eff = CW'(DMAX);
        end
        else
        begin
            eff = dim_ext;
        end
        top     = eff - CW'(1);
        ip_ext  = CW'(ip);
        lo_next = (ip_ext > top) ? top[DIM_BITS-1:0] : ip_ext[DIM_BITS-1:0];
        // zero fraction, or upper corner clamped onto lower: all weight goes to the lower corner
        same     = (f == '0) || (ip_ext >= top);
        whi_next = same ? '0 : {1'b0, f};
        wlo_next = same ? (FRAC_BITS + 1)'(ONE) : (FRAC_BITS + 1)'(ONE) - {1'b0, f};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg  <= lo_next;
            wlo_reg <= wlo_next;
            whi_reg <= whi_next;
        end
    end
endmodule

FILE: rtl/trilinear_voxel_sampler_top.sv
// trilinear voxel sampler top: eight parity banks, weight and blend pipeline
// depends on tvs_pkg, tvs_if, tvs_ram, tvs_axis and the defines header
//
//  channel   dir  handshake           payload
//  in_ch     in   valid/ready         req_type, write_x/y/z, voxel_value, pos_x/y/z
//  out_ch    out  valid/ready         sample_value
//  cfg       in   cfg_we              cfg_index, cfg_data
//
// one item per cycle while the output is not stalled
// the eight neighbours sit in eight banks chosen by coordinate parity, so all
// eight reads issue in the same cycle from one read port per bank
// a stalled output freezes the whole pipeline, the input then shows not ready
// reset clears control and sets the dimensions to 32; voxel data is not cleared
`include "trilinear_voxel_sampler_top_defines.svh"

module trilinear_voxel_sampler_top #(
    parameter int DIM_BITS   = 5,
    parameter int VOXEL_BITS = 16,
    parameter int FRAC_BITS  = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tvs_in_if.sink                            in_ch,
    tvs_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [tvs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tvs_pkg::DIM_REG_W-1:0]     cfg_data
);
    localparam int D      = DIM_BITS;
    localparam int VB     = VOXEL_BITS;
    localparam int F      = FRAC_BITS;
    localparam int WW     = F + 1;
    localparam int BANK_AW = 3 * (D - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int W2     = 2 * WW;
    localparam int W3     = 3 * WW;
    localparam int PRW    = VB + W3;
    localparam int SW     = PRW + 3;
    localparam int SHIFT  = 3 * F;
    localparam int RW     = SW - SHIFT;
    localparam int VMAX_I = (1 << VB) - 1;
    localparam int ONE    = 1 << F;

    // configuration
    logic [tvs_pkg::DIM_REG_W-1:0] dim_x_reg, dim_y_reg, dim_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= tvs_pkg::DIM_RESET;
            dim_y_reg <= tvs_pkg::DIM_RESET;
            dim_z_reg <= tvs_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (tvs_pkg::cfg_reg_t'(cfg_index))
                tvs_pkg::REG_DIM_X: dim_x_reg <= cfg_data;
                tvs_pkg::REG_DIM_Y: dim_y_reg <= cfg_data;
                tvs_pkg::REG_DIM_Z: dim_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic        en;
    logic [6:1]  vld_reg;
    logic        samp1_reg;
    logic        out_valid_reg;
    logic [VB-1:0] out_val_reg;

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // stage 1: axis split and write capture
    logic [D-1:0]  wr_x1_reg, wr_y1_reg, wr_z1_reg;
    logic [VB-1:0] wr_val1_reg;
    logic [D-1:0]  lo_x, lo_y, lo_z;
    logic [WW-1:0] wlo_x, whi_x, wlo_y, whi_y, wlo_z, whi_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wr_x1_reg   <= D'(in_ch.write_x);
            wr_y1_reg   <= D'(in_ch.write_y);
            wr_z1_reg   <= D'(in_ch.write_z);
            wr_val1_reg <= VB'(in_ch.voxel_value);
        end
    end

    tvs_axis #(.DIM_BITS(D), .FRAC_BITS(F)) u_axis_x (
        .clk(clk), .en(en), .pos(in_ch.pos_x), .dim(dim_x_reg),
        .lo_reg(lo_x), .wlo_reg(wlo_x), .whi_reg(whi_x));
    tvs_axis #(.DIM_BITS(D), .FRAC_BITS(F)) u_axis_y (
        .clk(clk), .en(en), .pos(in_ch.pos_y), .dim(dim_y_reg),
        .lo_reg(lo_y), .wlo_reg(wlo_y), .whi_reg(whi_y));
    tvs_axis #(.DIM_BITS(D), .FRAC_BITS(F)) u_axis_z (
        .clk(clk), .en(en), .pos(in_ch.pos_z), .dim(dim_z_reg),
        .lo_reg(lo_z), .wlo_reg(wlo_z), .whi_reg(whi_z));

    // parity banks
    logic [D-1:0]  lo_x1p, lo_y1p, lo_z1p;
    logic [VB-1:0] rdata [8];
    logic [2:0]    wr_bank;
    logic          wr_en;

    assign lo_x1p  = lo_x + D'(1);
    assign lo_y1p  = lo_y + D'(1);
    assign lo_z1p  = lo_z + D'(1);
    assign wr_bank = {wr_z1_reg[0], wr_y1_reg[0], wr_x1_reg[0]};
    assign wr_en   = en && vld_reg[1] && !samp1_reg;

    for (genvar b = 0; b < 8; b++)
    begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'((b / 2) % 2);
        localparam logic PZ = 1'((b / 4) % 2);
        logic [D-1:0]       xc, yc, zc;
        logic [BANK_AW-1:0] raddr;

        // the corner of matching parity is either lo or lo+1
        assign xc    = (lo_x[0] == PX) ? lo_x : lo_x1p;
        assign yc    = (lo_y[0] == PY) ? lo_y : lo_y1p;
        assign zc    = (lo_z[0] == PZ) ? lo_z : lo_z1p;
        assign raddr = {zc[D-1:1], yc[D-1:1], xc[D-1:1]};

        tvs_ram #(.WIDTH(VB), .DEPTH(BANK_DEPTH)) u_ram (
            .clk   (clk),
            .we    (wr_en && (wr_bank == 3'(b))),
            .waddr ({wr_z1_reg[D-1:1], wr_y1_reg[D-1:1], wr_x1_reg[D-1:1]}),
            .wdata (wr_val1_reg),
            .re    (en),
            .raddr (raddr),
            .rdata (rdata[b])
        );
    end

    // stage 2 carries parities and weights alongside the read
    logic [2:0]    par2_reg;
    logic [WW-1:0] wx2_reg [2];
    logic [WW-1:0] wy2_reg [2];
    logic [WW-1:0] wz2_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par2_reg   <= {lo_z[0], lo_y[0], lo_x[0]};
            wx2_reg[0] <= wlo_x;
            wx2_reg[1] <= whi_x;
            wy2_reg[0] <= wlo_y;
            wy2_reg[1] <= whi_y;
            wz2_reg[0] <= wlo_z;
            wz2_reg[1] <= whi_z;
        end
    end

    // route banks to neighbours; a neighbour of zero weight reads as zero
    logic [VB-1:0] val2 [8];
    logic [W2-1:0] wxy2 [4];

    always_comb
    begin
        for (int n = 0; n < 8; n++)
        begin
            val2[n] = ((n[0] == 1'b0) || (wx2_reg[1] != '0))
                   && ((n[1] == 1'b0) || (wy2_reg[1] != '0))
                   && ((n[2] == 1'b0) || (wz2_reg[1] != '0))
                   ? rdata[par2_reg ^ 3'(n)] : '0;
        end
        for (int m = 0; m < 4; m++)
        begin
            wxy2[m] = W2'(wx2_reg[m % 2]) * W2'(wy2_reg[m / 2]);
        end
    end

    // stage 3
    logic [VB-1:0] val3_reg [8];
    logic [W2-1:0] wxy3_reg [4];
    logic [WW-1:0] wz3_reg [2];
    // stage 4
    logic [VB-1:0] val4_reg [8];
    logic [W3-1:0] w4_reg [8];
    // stage 5
    logic [PRW-1:0] prod5_reg [8];
    // stage 6
    logic [SW-1:0] psum6_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val3_reg <= val2;
            wxy3_reg <= wxy2;
            wz3_reg  <= wz2_reg;
            val4_reg <= val3_reg;
            for (int n = 0; n < 8; n++)
            begin
                w4_reg[n]    <= W3'(wxy3_reg[n % 4]) * W3'(wz3_reg[n / 4]);
                prod5_reg[n] <= PRW'(val4_reg[n]) * PRW'(w4_reg[n]);
            end
            for (int h = 0; h < 2; h++)
            begin
                psum6_reg[h] <= SW'(prod5_reg[4*h]) + SW'(prod5_reg[4*h+1])
                              + SW'(prod5_reg[4*h+2]) + SW'(prod5_reg[4*h+3]);
            end
        end
    end

    // round half up, saturate
    logic [SW-1:0] total;
    logic [RW-1:0] rnd;
    logic [VB-1:0] res;

    always_comb
    begin
        total = psum6_reg[0] + psum6_reg[1] + (SW'(1) << (SHIFT - 1));
        rnd   = total[SW-1:SHIFT];
        res   = (rnd > RW'(VMAX_I)) ? VB'(VMAX_I) : rnd[VB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            samp1_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1]    <= in_ch.valid;
            samp1_reg     <= (in_ch.req_type == tvs_pkg::REQ_SAMPLE);
            vld_reg[2]    <= vld_reg[1] && samp1_reg;
            vld_reg[6:3]  <= vld_reg[5:2];
            out_valid_reg <= vld_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_val_reg <= res;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.sample_value = tvs_pkg::VOXEL_W'(out_val_reg);

    logic wsum_ok;
    assign wsum_ok = ({1'b0, wlo_x} + {1'b0, whi_x} == (WW + 1)'(ONE))
                  && ({1'b0, wlo_y} + {1'b0, whi_y} == (WW + 1)'(ONE))
                  && ({1'b0, wlo_z} + {1'b0, whi_z} == (WW + 1)'(ONE));

    `TVS_ASSERT_NXT(a_stall_freeze, out_ch.valid && !out_ch.ready, $stable(vld_reg), "pipeline moved during stall")
    `TVS_ASSERT_NXT(a_write_no_result, en && vld_reg[1] && !samp1_reg, !vld_reg[2], "write item entered blend pipeline")
    `TVS_ASSERT_IMP(a_weight_sum, vld_reg[1] && samp1_reg, wsum_ok, "axis weights do not sum to one")
endmodule
